[design/smcd_pkg.sv]
// ----------------------------------------------------------------------------
// Serial motor command decoder package
// Character codes, line limits and the constants of the divide by 100.
// ----------------------------------------------------------------------------
package smcd_pkg;

  localparam int unsigned LINE_CAPACITY = 49;
  localparam int unsigned PWM_PERIOD    = 1000;

  localparam logic [9:0] VOLTAGE_LIMIT_RESET = 10'd416;
  localparam logic [9:0] CMP_MAX             = 10'h3FF;
  localparam logic [6:0] SPEED_MAX           = 7'd100;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_M  = 8'd77;
  localparam logic [7:0] CH_UP_R  = 8'd82;
  localparam logic [7:0] CH_LO_R  = 8'd114;

  // Product of speed and limit fits in 17 bits; the reciprocal is exact there.
  localparam int unsigned PROD_W       = 17;
  localparam int unsigned DIV100_SHIFT = 24;
  localparam logic [17:0] DIV100_MULT  = 18'd167773;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] push_digit(input logic [7:0] acc, input logic [7:0] c);
    logic [7:0] dig;
    dig = c - CH_ZERO;
    return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + dig;
  endfunction

endpackage

[design/serial_motor_command_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Serial motor command decoder unit
// Parses "M<int> <char> <int>" command lines byte by byte and emits one
// status and PWM compare beat for every CR or LF.
// ----------------------------------------------------------------------------
// Channel   Valid        Stall         Payload
// in        in_valid_i   in_stall_o    rx_byte_i
// out       out_valid_o  out_stall_i   status_o, motor_number_o, drives_channel_o,
//                                      reverse_o, speed_percent_o, compare_value_o
// cfg       cfg_we_i     -             cfg_wdata_i
//
// One beat is accepted every cycle while in_stall_o is low; the parser state
// updates in the same cycle. A line end is registered after the speed times
// limit product and again after the divide by 100 and reverse offset.
// Reset clears the parser, empties the pipeline and loads the limit with 416.
// A stalled output holds its beat while the product stage still takes one more.
module serial_motor_command_decoder_unit
  import smcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  output logic [7:0] motor_number_o,
  output logic       drives_channel_o,
  output logic       reverse_o,
  output logic [6:0] speed_percent_o,
  output logic [9:0] compare_value_o
);

  typedef enum logic [3:0] {
    PH_LETTER,
    PH_M_SPACE,
    PH_M_SIGN,
    PH_M_DIGITS,
    PH_CHAR,
    PH_S_SPACE,
    PH_S_SIGN,
    PH_S_DIGITS,
    PH_DONE,
    PH_FAIL
  } phase_e;

  logic [9:0]  limit_q;
  phase_e      ph_q, ph_d;
  logic [5:0]  pos_q, pos_d;
  logic [7:0]  macc_q, macc_d;
  logic        mneg_q, mneg_d;
  logic [7:0]  sacc_q, sacc_d;
  logic        sneg_q, sneg_d;
  logic        rev_q, rev_d;

  logic              s1_valid_q;
  logic              s1_ok_q;
  logic [7:0]        s1_motor_q;
  logic              s1_rev_q;
  logic [6:0]        s1_speed_q;
  logic [PROD_W-1:0] s1_prod_q;

  logic       out_valid_q;
  logic       out_status_q;
  logic [7:0] out_motor_q;
  logic       out_drive_q;
  logic       out_rev_q;
  logic [6:0] out_speed_q;
  logic [9:0] out_cmp_q;

  logic              in_fire;
  logic              is_eol;
  logic              out_free;
  logic              s1_free;
  logic              line_ok;
  logic [7:0]        motor_val;
  logic [7:0]        speed_val;
  logic [6:0]        speed_clamp;
  logic [PROD_W-1:0] prod;
  logic [PROD_W+17:0] div_full;
  logic [10:0]       target;
  logic [15:0]       rev_cmp;
  logic [15:0]       cmp_sel;
  logic [9:0]        cmp_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_eol     = (rx_byte_i == CH_LF) || (rx_byte_i == CH_CR);

  always_comb begin
    ph_d   = ph_q;
    pos_d  = pos_q;
    macc_d = macc_q;
    mneg_d = mneg_q;
    sacc_d = sacc_q;
    sneg_d = sneg_q;
    rev_d  = rev_q;
    if (in_fire) begin
      if (is_eol) begin
        ph_d   = PH_LETTER;
        pos_d  = '0;
        macc_d = '0;
        mneg_d = 1'b0;
        sacc_d = '0;
        sneg_d = 1'b0;
        rev_d  = 1'b0;
      end else if (pos_q < 6'(LINE_CAPACITY)) begin
        pos_d = pos_q + 6'd1;
        if (rx_byte_i == CH_NUL) begin
          ph_d = ((ph_q == PH_S_DIGITS) || (ph_q == PH_DONE)) ? PH_DONE : PH_FAIL;
        end else begin
          case (ph_q)
            PH_LETTER: begin
              ph_d = (rx_byte_i == CH_UP_M) ? PH_M_SPACE : PH_FAIL;
            end
            PH_M_SPACE: begin
              if (!is_space(rx_byte_i)) begin
                if ((rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS)) begin
                  mneg_d = (rx_byte_i == CH_MINUS);
                  ph_d   = PH_M_SIGN;
                end else if (is_digit(rx_byte_i)) begin
                  macc_d = push_digit(8'd0, rx_byte_i);
                  ph_d   = PH_M_DIGITS;
                end else begin
                  ph_d = PH_FAIL;
                end
              end
            end
            PH_M_SIGN: begin
              if (is_digit(rx_byte_i)) begin
                macc_d = push_digit(8'd0, rx_byte_i);
                ph_d   = PH_M_DIGITS;
              end else begin
                ph_d = PH_FAIL;
              end
            end
            PH_M_DIGITS: begin
              if (is_digit(rx_byte_i)) begin
                macc_d = push_digit(macc_q, rx_byte_i);
              end else if (is_space(rx_byte_i)) begin
                ph_d = PH_CHAR;
              end else begin
                rev_d = (rx_byte_i == CH_UP_R) || (rx_byte_i == CH_LO_R);
                ph_d  = PH_S_SPACE;
              end
            end
            PH_CHAR: begin
              if (!is_space(rx_byte_i)) begin
                rev_d = (rx_byte_i == CH_UP_R) || (rx_byte_i == CH_LO_R);
                ph_d  = PH_S_SPACE;
              end
            end
            PH_S_SPACE: begin
              if (!is_space(rx_byte_i)) begin
                if ((rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS)) begin
                  sneg_d = (rx_byte_i == CH_MINUS);
                  ph_d   = PH_S_SIGN;
                end else if (is_digit(rx_byte_i)) begin
                  sacc_d = push_digit(8'd0, rx_byte_i);
                  ph_d   = PH_S_DIGITS;
                end else begin
                  ph_d = PH_FAIL;
                end
              end
            end
            PH_S_SIGN: begin
              if (is_digit(rx_byte_i)) begin
                sacc_d = push_digit(8'd0, rx_byte_i);
                ph_d   = PH_S_DIGITS;
              end else begin
                ph_d = PH_FAIL;
              end
            end
            PH_S_DIGITS: begin
              if (is_digit(rx_byte_i)) begin
                sacc_d = push_digit(sacc_q, rx_byte_i);
              end else begin
                ph_d = PH_DONE;
              end
            end
            default: begin
              ph_d = ph_q;
            end
          endcase
        end
      end
    end
  end

  assign line_ok     = (ph_q == PH_DONE) || (ph_q == PH_S_DIGITS);
  assign motor_val   = mneg_q ? (8'd0 - macc_q) : macc_q;
  assign speed_val   = sneg_q ? (8'd0 - sacc_q) : sacc_q;
  assign speed_clamp = (speed_val > {1'b0, SPEED_MAX}) ? SPEED_MAX : speed_val[6:0];
  assign prod        = PROD_W'(speed_clamp) * PROD_W'(limit_q);

  assign div_full = (PROD_W+18)'(s1_prod_q) * (PROD_W+18)'(DIV100_MULT);
  assign target   = div_full[DIV100_SHIFT +: 11];
  assign rev_cmp  = (16'(PWM_PERIOD) > 16'(target)) ? (16'(PWM_PERIOD) - 16'(target)) : 16'd0;
  assign cmp_sel  = s1_rev_q ? rev_cmp : 16'(target);
  assign cmp_val  = (cmp_sel > 16'(CMP_MAX)) ? CMP_MAX : cmp_sel[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= VOLTAGE_LIMIT_RESET;
      ph_q        <= PH_LETTER;
      pos_q       <= '0;
      macc_q      <= '0;
      mneg_q      <= 1'b0;
      sacc_q      <= '0;
      sneg_q      <= 1'b0;
      rev_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      macc_q <= macc_d;
      mneg_q <= mneg_d;
      sacc_q <= sacc_d;
      sneg_q <= sneg_d;
      rev_q  <= rev_d;
      if (in_fire && is_eol) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_eol) begin
      s1_ok_q    <= line_ok;
      s1_motor_q <= line_ok ? motor_val : 8'd0;
      s1_rev_q   <= line_ok ? rev_q : 1'b0;
      s1_speed_q <= line_ok ? speed_clamp : 7'd0;
      s1_prod_q  <= line_ok ? prod : '0;
    end
    if (s1_valid_q && out_free) begin
      out_status_q <= !s1_ok_q;
      out_motor_q  <= s1_motor_q;
      out_drive_q  <= s1_ok_q && (s1_motor_q >= 8'd1) && (s1_motor_q <= 8'd4);
      out_rev_q    <= s1_rev_q;
      out_speed_q  <= s1_speed_q;
      out_cmp_q    <= cmp_val;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign motor_number_o   = out_motor_q;
  assign drives_channel_o = out_drive_q;
  assign reverse_o        = out_rev_q;
  assign speed_percent_o  = out_speed_q;
  assign compare_value_o  = out_cmp_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 6'(LINE_CAPACITY))
    else $error("line position beyond capacity");

  a_eol_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_eol) |=> (s1_valid_q && (pos_q == 6'd0) && (ph_q == PH_LETTER)))
    else $error("line end did not load the product stage or clear the parser");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |->
      ((out_cmp_q == 10'd0) && (out_motor_q == 8'd0) && (out_speed_q == 7'd0) && !out_rev_q))
    else $error("format error beat carries nonzero fields");

  a_drive_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drive_q) |->
      (!out_status_q && (out_motor_q >= 8'd1) && (out_motor_q <= 8'd4)))
    else $error("channel drive flag without a valid motor number");

  a_speed_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_speed_q <= SPEED_MAX))
    else $error("speed above clamp");

endmodule

[test/serial_motor_command_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// Serial motor command decoder unit testbench
// Feeds command lines byte by byte, first from a short table of fixed lines
// and then as random well-formed, broken and noise lines under several limit
// settings. A built-in line parser predicts each result beat that no table
// row gives itself; each beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module serial_motor_command_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned PHASE_BYTES = 205;

  typedef enum logic [3:0] {
    ST_WANT_M, ST_MOTOR_WS, ST_MOTOR_SIGN, ST_MOTOR_NUM, ST_LETTER_WS,
    ST_SPEED_WS, ST_SPEED_SIGN, ST_SPEED_NUM, ST_LINE_OK, ST_LINE_BAD
  } line_state_e;

  typedef struct packed {
    logic       status;
    logic [7:0] motor;
    logic       drives;
    logic       rev;
    logic [6:0] speed;
    logic [9:0] cmp;
  } motor_cmd_t;

  typedef struct {
    string      text;
    bit         typed;
    motor_cmd_t want;
  } script_row_t;

  localparam motor_cmd_t BAD_LINE = '{status: 1'b1, default: '0};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [9:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       status_o;
  logic [7:0] motor_number_o;
  logic       drives_channel_o;
  logic       reverse_o;
  logic [6:0] speed_percent_o;
  logic [9:0] compare_value_o;

  serial_motor_command_decoder_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .motor_number_o   (motor_number_o),
    .drives_channel_o (drives_channel_o),
    .reverse_o        (reverse_o),
    .speed_percent_o  (speed_percent_o),
    .compare_value_o  (compare_value_o)
  );

  // Line parser state of the prediction.
  line_state_e st;
  int unsigned line_len;
  logic [7:0]  motor_acc;
  logic        motor_neg;
  logic [7:0]  speed_acc;
  logic        speed_neg;
  logic        rev_sel;
  logic [9:0]  volt_limit;

  motor_cmd_t  motor_cmd_q[$];
  motor_cmd_t  typed_cmd;
  bit          use_typed;
  logic [7:0]  line_bytes[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  // In the text of a row, '^' stands for a zero byte and '*' for 43 '0' digits.
  script_row_t directed_rows[18] = '{
    '{"\015",                   1'b1, BAD_LINE},
    '{"M1 F 100\n",             1'b1, '{1'b0, 8'd1, 1'b1, 1'b0, 7'd100, 10'd416}},
    '{"M4 R 100\n",             1'b1, '{1'b0, 8'd4, 1'b1, 1'b1, 7'd100, 10'd584}},
    '{"M0 F 0\n",               1'b1, '{1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 10'd0}},
    '{"M255 r 255\015",         1'b1, '{1'b0, 8'd255, 1'b0, 1'b1, 7'd100, 10'd584}},
    '{"M256 F 50\n",            1'b0, '0},
    '{"M-1 f -156\n",           1'b0, '0},
    '{"M\t+3\013x\014+7  junk\n", 1'b0, '0},
    '{"M2R9\n",                 1'b0, '0},
    '{"X1 F 5\n",               1'b1, BAD_LINE},
    '{"m1 F 5\n",               1'b1, BAD_LINE},
    '{"M2 R\n",                 1'b1, BAD_LINE},
    '{"M+ F 1\n",               1'b1, BAD_LINE},
    '{"M1 F 5^junk\n",          1'b0, '0},
    '{"M1 F^ 5\n",              1'b1, BAD_LINE},
    '{"M1 F *123\n",            1'b1, '{1'b0, 8'd1, 1'b1, 1'b0, 7'd1, 10'd4}},
    '{"M1 - -0\n",              1'b0, '0},
    '{"M3 F 9\377\n",           1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_line();
    st        = ST_WANT_M;
    line_len  = 0;
    motor_acc = '0;
    motor_neg = 1'b0;
    speed_acc = '0;
    speed_neg = 1'b0;
    rev_sel   = 1'b0;
  endfunction

  function automatic void advance_parser(input logic [7:0] b);
    logic blank;
    logic digit;
    logic sign;
    blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    sign  = (b == CH_PLUS) || (b == CH_MINUS);
    if (b == CH_NUL) begin
      st = ((st == ST_SPEED_NUM) || (st == ST_LINE_OK)) ? ST_LINE_OK : ST_LINE_BAD;
    end else begin
      case (st)
        ST_WANT_M: st = (b == CH_UP_M) ? ST_MOTOR_WS : ST_LINE_BAD;
        ST_MOTOR_WS, ST_MOTOR_SIGN: begin
          if (sign && st == ST_MOTOR_WS) begin
            motor_neg = (b == CH_MINUS);
            st = ST_MOTOR_SIGN;
          end else if (digit) begin
            motor_acc = b - CH_ZERO;
            st = ST_MOTOR_NUM;
          end else if (!(blank && st == ST_MOTOR_WS)) begin
            st = ST_LINE_BAD;
          end
        end
        ST_MOTOR_NUM, ST_LETTER_WS: begin
          if (digit && st == ST_MOTOR_NUM) begin
            motor_acc = motor_acc * 8'd10 + (b - CH_ZERO);
          end else if (blank) begin
            st = ST_LETTER_WS;
          end else begin
            rev_sel = (b == CH_UP_R) || (b == CH_LO_R);
            st = ST_SPEED_WS;
          end
        end
        ST_SPEED_WS, ST_SPEED_SIGN: begin
          if (sign && st == ST_SPEED_WS) begin
            speed_neg = (b == CH_MINUS);
            st = ST_SPEED_SIGN;
          end else if (digit) begin
            speed_acc = b - CH_ZERO;
            st = ST_SPEED_NUM;
          end else if (!(blank && st == ST_SPEED_WS)) begin
            st = ST_LINE_BAD;
          end
        end
        ST_SPEED_NUM: begin
          if (digit) speed_acc = speed_acc * 8'd10 + (b - CH_ZERO);
          else st = ST_LINE_OK;
        end
        default: begin
        end
      endcase
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    motor_cmd_t  res;
    logic [7:0]  mval;
    logic [7:0]  sval;
    int unsigned spd;
    int unsigned target;
    int unsigned cmp_v;
    if (b == CH_LF || b == CH_CR) begin
      res = BAD_LINE;
      if (st == ST_LINE_OK || st == ST_SPEED_NUM) begin
        mval = motor_neg ? 8'd0 - motor_acc : motor_acc;
        sval = speed_neg ? 8'd0 - speed_acc : speed_acc;
        spd = (sval > SPEED_MAX) ? 32'(SPEED_MAX) : 32'(sval);
        target = spd * 32'(volt_limit) / 100;
        if (rev_sel) cmp_v = (PWM_PERIOD > target) ? PWM_PERIOD - target : 0;
        else cmp_v = target;
        if (cmp_v > 32'(CMP_MAX)) cmp_v = 32'(CMP_MAX);
        res.status = 1'b0;
        res.motor  = mval;
        res.drives = (mval >= 8'd1) && (mval <= 8'd4);
        res.rev    = rev_sel;
        res.speed  = 7'(spd);
        res.cmp    = 10'(cmp_v);
      end
      motor_cmd_q.push_back(use_typed ? typed_cmd : res);
      clear_line();
    end else if (line_len < LINE_CAPACITY) begin
      line_len++;
      advance_parser(b);
    end
  endfunction

  function automatic bit take_break();
    return !quiet && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_TAB;
      1: return 8'd11;
      2: return 8'd12;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 5))
      0, 1: return CH_UP_R;
      2: return CH_LO_R;
      3, 4: return "F";
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic void add_blanks(input int unsigned n);
    repeat (n) line_bytes.push_back(pick_blank());
  endfunction

  function automatic void add_number(input int unsigned value);
    string digits;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) line_bytes.push_back(CH_PLUS);
    else if (pick == 1) line_bytes.push_back(CH_MINUS);
    if ($urandom_range(0, 9) == 0) line_bytes.push_back(CH_ZERO);
    digits = $sformatf("%0d", value);
    for (int k = 0; k < digits.len(); k++) line_bytes.push_back(digits[k]);
  endfunction

  function automatic void make_line();
    int unsigned pick;
    int unsigned pos;
    logic [7:0]  pad;
    line_bytes.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_bytes.push_back(($urandom_range(0, 19) == 0) ? pick_letter() : CH_UP_M);
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(0, 29) != 0) begin
        add_number(($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(0, 999));
      end
      add_blanks($urandom_range(0, 2));
      line_bytes.push_back(pick_letter());
      add_blanks($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (pick < 3) add_number(100);
      else if (pick == 3) add_number(255);
      else if (pick != 4) add_number($urandom_range(0, 300));
      if ($urandom_range(0, 6) == 0) begin
        line_bytes.push_back(pick_letter());
        add_number($urandom_range(0, 99));
      end
      if ($urandom_range(0, 19) == 0) begin
        line_bytes.insert($urandom_range(0, line_bytes.size()), CH_NUL);
      end
      if ($urandom_range(0, 19) == 0) begin
        pos = ($urandom_range(0, 1) == 0) ? line_bytes.size() : $urandom_range(1, line_bytes.size());
        pad = ($urandom_range(0, 1) == 0) ? CH_ZERO : pick_blank();
        repeat ($urandom_range(40, 60)) line_bytes.insert(pos, pad);
      end
      if ($urandom_range(0, 19) == 0) begin
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    line_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
  endfunction

  task automatic report_mismatch(input string what, input logic [9:0] got,
                                 input logic [9:0] want);
    if (mismatch_count < 50) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [9:0] got,
                             input logic [9:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit taken;
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    parse_rx_byte(b);
  endtask

  task automatic run_random_lines(input int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      make_line();
      foreach (line_bytes[k]) send_byte(line_bytes[k]);
      sent += line_bytes.size();
    end
  endtask

  task automatic drain_results();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (motor_cmd_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic write_limit(input logic [9:0] value);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    volt_limit = value;
  endtask

  // Result side: stalls at random, once holds off long enough to back up the input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= take_break();
      end
    end
  end

  initial begin
    motor_cmd_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (motor_cmd_q.size() == 0) begin
          report_mismatch("beat with no command expected", 10'(status_o), '0);
        end else begin
          want = motor_cmd_q.pop_front();
          check_field("status", 10'(status_o), 10'(want.status));
          check_field("motor_number", 10'(motor_number_o), 10'(want.motor));
          check_field("drives_channel", 10'(drives_channel_o), 10'(want.drives));
          check_field("reverse", 10'(reverse_o), 10'(want.rev));
          check_field("speed_percent", 10'(speed_percent_o), 10'(want.speed));
          check_field("compare_value", compare_value_o, want.cmp);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("serial_motor_command_decoder_unit test failed");
    $finish;
  end

  initial begin
    logic [7:0] ch;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    rx_byte_i      = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    use_typed      = 1'b0;
    typed_cmd      = '0;
    mismatch_count = 0;
    volt_limit     = VOLTAGE_LIMIT_RESET;
    clear_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      use_typed = directed_rows[r].typed;
      typed_cmd = directed_rows[r].want;
      for (int k = 0; k < directed_rows[r].text.len(); k++) begin
        ch = directed_rows[r].text[k];
        if (ch == "^") send_byte(CH_NUL);
        else if (ch == "*") repeat (43) send_byte(CH_ZERO);
        else send_byte(ch);
      end
    end
    use_typed = 1'b0;

    run_random_lines(PHASE_BYTES);
    write_limit(10'd1000);
    quiet = 1'b1;
    run_random_lines(PHASE_BYTES);
    quiet = 1'b0;
    write_limit(10'd0);
    hold_req = 1'b1;
    run_random_lines(PHASE_BYTES);
    write_limit(CMP_MAX);
    run_random_lines(PHASE_BYTES);
    write_limit(10'($urandom_range(0, 1023)));
    run_random_lines(PHASE_BYTES);
    write_limit(VOLTAGE_LIMIT_RESET);
    run_random_lines(PHASE_BYTES);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (motor_cmd_q.size() != 0) begin
      report_mismatch("commands never delivered", 10'(motor_cmd_q.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("serial_motor_command_decoder_unit test passed");
    end else begin
      $display("serial_motor_command_decoder_unit test failed");
    end
    $finish;
  end

endmodule
